FILE: design/assert_macros.svh
// Assertion macros shared by the glyph layout RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

FILE: design/glk_pkg.sv
// Shared types, constants and saturation helpers for the glyph layout block.
// No dependencies; imported by every glk_* module except glk_ram, and by the top level.
`timescale 1ns / 1ps
`default_nettype none

package glk_pkg;

  localparam int GLYPH_ENTRIES = 256;
  localparam int KERN_ENTRIES  = 65536;
  localparam int POS_FRAC_BITS = 4;

  localparam int GLYPH_AW    = $clog2(GLYPH_ENTRIES);
  localparam int KERN_AW     = $clog2(KERN_ENTRIES);
  localparam int SCALE_SHIFT = 8 - POS_FRAC_BITS;
  localparam int FP_W        = 12 + POS_FRAC_BITS;

  localparam logic signed [31:0] S20_MAX = 32'sd524287;
  localparam logic signed [31:0] S20_MIN = -32'sd524288;
  localparam logic signed [31:0] U19_MAX = 32'sd524287;

  // cursor is two pixels wide
  localparam logic signed [19:0] CURSOR_W = 20'(2 << POS_FRAC_BITS);

  // config register indexes
  localparam logic [2:0] REG_SCALE     = 3'd0;
  localparam logic [2:0] REG_FONT_PX   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd3;
  localparam logic [2:0] REG_CAPTURE   = 3'd4;
  localparam logic [2:0] REG_CURSOR    = 3'd5;
  localparam logic [2:0] REG_SEL_BEGIN = 3'd6;
  localparam logic [2:0] REG_SEL_END   = 3'd7;

  typedef enum logic [1:0] {
    OP_GLYPH = 2'd0,
    OP_KERN  = 2'd1,
    OP_CHAR  = 2'd2,
    OP_END   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_GLYPH  = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_SELECT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0]        scale_q8;
    logic [11:0]        font_px;
    logic signed [19:0] origin_x;
    logic signed [19:0] origin_y;
    logic               capture_on;
    logic [15:0]        cursor_index;
    logic [15:0]        select_begin;
    logic [15:0]        select_end;
  } cfg_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  w;
    logic [7:0]  h;
  } geo_t;

  typedef struct packed {
    logic signed [7:0] bx;
    logic signed [7:0] by;
    logic signed [8:0] adv;
  } met_t;

  // table write request
  typedef struct packed {
    logic                glyph_we;
    logic [GLYPH_AW-1:0] glyph_addr;
    geo_t                geo;
    met_t                met;
    logic                kern_we;
    logic [KERN_AW-1:0]  kern_addr;
    logic signed [7:0]   kern;
  } tbl_wr_t;

  // table read request
  typedef struct packed {
    logic                re;
    logic [GLYPH_AW-1:0] glyph_addr;
    logic [KERN_AW-1:0]  kern_addr;
  } tbl_rd_t;

  // line item waiting for its table data
  typedef struct packed {
    op_t         op;
    logic [15:0] index;
    logic        glyph_in;
    logic        kern_in;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] w;
    logic [18:0]        h;
    logic [11:0]        sx;
    logic [11:0]        sy;
    logic [7:0]         sw;
    logic [7:0]         sh;
    logic               last;
  } result_t;

  // all results of one item, in delivery order
  typedef struct packed {
    logic       push;
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } bundle_t;

  function automatic logic signed [19:0] sat_s20(input logic signed [31:0] v);
    logic signed [19:0] r;
    if (v > S20_MAX) r = S20_MAX[19:0];
    else if (v < S20_MIN) r = S20_MIN[19:0];
    else r = v[19:0];
    return r;
  endfunction

  function automatic logic [18:0] sat_u19(input logic signed [31:0] v);
    logic [18:0] r;
    if (v < 0) r = '0;
    else if (v > U19_MAX) r = U19_MAX[18:0];
    else r = v[18:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/glk_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module glk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/glk_tables.sv
// Glyph geometry, glyph metrics and kerning storage with valid bits and
// the post-reset kerning clear sweep. Uses glk_pkg and glk_ram.
`timescale 1ns / 1ps
`default_nettype none

module glk_tables import glk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tbl_wr_t           wr,
  input  wire tbl_rd_t           rd,
  output      geo_t              geo_q,
  output      met_t              met_q,
  output      logic              valid_q,
  output      logic signed [7:0] kern_q,
  output      logic              clearing
);

  logic [GLYPH_ENTRIES-1:0] valid;
  logic [KERN_AW-1:0]       clr_addr;

  logic               k_we;
  logic [KERN_AW-1:0] k_waddr;
  logic [7:0]         k_wdata;

  // sweep owns the kerning write port until every entry is zero
  always_comb begin
    if (clearing) begin
      k_we    = 1'b1;
      k_waddr = clr_addr;
      k_wdata = '0;
    end else begin
      k_we    = wr.kern_we;
      k_waddr = wr.kern_addr;
      k_wdata = wr.kern;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      valid    <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == KERN_AW'(KERN_ENTRIES - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (wr.glyph_we) begin
        valid[wr.glyph_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      valid_q <= valid[rd.glyph_addr];
    end
  end

  glk_ram #(.WIDTH($bits(geo_t)), .DEPTH(GLYPH_ENTRIES)) u_geo (
    .clk   (clk),
    .we    (wr.glyph_we),
    .waddr (wr.glyph_addr),
    .wdata (wr.geo),
    .re    (rd.re),
    .raddr (rd.glyph_addr),
    .rdata (geo_q)
  );

  glk_ram #(.WIDTH($bits(met_t)), .DEPTH(GLYPH_ENTRIES)) u_met (
    .clk   (clk),
    .we    (wr.glyph_we),
    .waddr (wr.glyph_addr),
    .wdata (wr.met),
    .re    (rd.re),
    .raddr (rd.glyph_addr),
    .rdata (met_q)
  );

  glk_ram #(.WIDTH(8), .DEPTH(KERN_ENTRIES)) u_kern (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .re    (rd.re),
    .raddr (rd.kern_addr),
    .rdata (kern_q)
  );

endmodule

`default_nettype wire

FILE: design/glk_front.sv
// Request intake: table writes for load requests, table reads and the
// character counter for line requests, and the item register. Uses glk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module glk_front import glk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [1:0]        opcode,
  input  wire logic [7:0]        code,
  input  wire logic [7:0]        first_code,
  input  wire logic [11:0]       atlas_x,
  input  wire logic [11:0]       atlas_y,
  input  wire logic [7:0]        glyph_w,
  input  wire logic [7:0]        glyph_h,
  input  wire logic signed [7:0] bearing_x,
  input  wire logic signed [7:0] bearing_y,
  input  wire logic signed [8:0] amount,
  input  wire logic              clearing,
  input  wire logic              s1_take,
  output      tbl_wr_t           wr,
  output      tbl_rd_t           rd,
  output      logic              s1_valid,
  output      item_t             item
);

  logic [7:0]  prev_char;
  logic [15:0] char_index;

  op_t         op;
  logic        acc;
  logic        line_req;
  logic [15:0] load_kidx;
  logic [15:0] look_kidx;
  logic        glyph_in;

  assign op        = op_t'(opcode);
  assign in_ready  = !clearing && (!s1_valid || s1_take);
  assign acc       = in_valid && in_ready;
  assign line_req  = (op == OP_CHAR) || (op == OP_END);
  assign load_kidx = {first_code, code};
  assign look_kidx = {prev_char, code};
  assign glyph_in  = int'(code) < GLYPH_ENTRIES;

  always_comb begin
    wr            = '0;
    wr.glyph_we   = acc && (op == OP_GLYPH) && glyph_in;
    wr.glyph_addr = code[GLYPH_AW-1:0];
    wr.geo        = '{x: atlas_x, y: atlas_y, w: glyph_w, h: glyph_h};
    wr.met        = '{bx: bearing_x, by: bearing_y, adv: amount};
    wr.kern_we    = acc && (op == OP_KERN) && (int'(load_kidx) < KERN_ENTRIES);
    wr.kern_addr  = load_kidx[KERN_AW-1:0];
    if (amount > 9'sd127) wr.kern = 8'sd127;
    else if (amount < -9'sd128) wr.kern = -8'sd128;
    else wr.kern = amount[7:0];

    rd.re         = acc && line_req;
    rd.glyph_addr = code[GLYPH_AW-1:0];
    rd.kern_addr  = look_kidx[KERN_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      prev_char  <= '0;
      char_index <= '0;
    end else begin
      if (acc && line_req) begin
        s1_valid <= 1'b1;
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
      if (acc && (op == OP_CHAR)) begin
        prev_char  <= code;
        char_index <= char_index + 1'b1;
      end else if (acc && (op == OP_END)) begin
        prev_char  <= '0;
        char_index <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && line_req) begin
      item.op       <= op;
      item.index    <= char_index;
      item.glyph_in <= glyph_in;
      item.kern_in  <= int'(look_kidx) < KERN_ENTRIES;
    end
  end

endmodule

`default_nettype wire

FILE: design/glk_place.sv
// Line state (pen, selection start); glyph, cursor, selection placement
// for one line request per cycle while out_free is high. Uses glk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module glk_place import glk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              s1_valid,
  input  wire item_t             item,
  input  wire geo_t              geo,
  input  wire met_t              met,
  input  wire logic              valid_q,
  input  wire logic signed [7:0] kern_q,
  input  wire logic              out_free,
  output      logic              s1_take,
  output      bundle_t           bundle
);

  logic signed [19:0] pen_x;
  logic signed [19:0] sel_left;
  logic               line_open;

  logic signed [19:0] pen_eff;
  logic               glyph_ok;
  logic signed [7:0]  kern_eff;
  logic signed [16:0] scale_s;

  logic signed [24:0] p_bx, p_by, sc_bx, sc_by;
  logic [23:0]        p_w, p_h;
  logic signed [9:0]  adv_k;
  logic signed [26:0] p_adv, sc_adv;
  logic signed [19:0] pen_adv;

  logic [FP_W-1:0]    fp;
  logic [FP_W+1:0]    fp3;

  logic    cap_go, cur_hit, sel_ok, sel_begin, sel_end;
  logic    g, c, s;
  logic [1:0] cnt;
  result_t rg, rc, rs;

  assign pen_eff  = line_open ? pen_x : cfg.origin_x;
  assign glyph_ok = (item.op == OP_CHAR) && item.glyph_in && valid_q;
  assign kern_eff = item.kern_in ? kern_q : 8'sd0;
  assign scale_s  = signed'({1'b0, cfg.scale_q8});

  // scaled values round toward minus infinity
  assign p_bx   = met.bx * scale_s;
  assign p_by   = met.by * scale_s;
  assign sc_bx  = p_bx >>> SCALE_SHIFT;
  assign sc_by  = p_by >>> SCALE_SHIFT;
  assign p_w    = geo.w * cfg.scale_q8;
  assign p_h    = geo.h * cfg.scale_q8;
  assign adv_k  = 10'(met.adv) + 10'(kern_eff);
  assign p_adv  = adv_k * scale_s;
  assign sc_adv = p_adv >>> SCALE_SHIFT;
  assign pen_adv = sat_s20(32'(pen_eff) + 32'(sc_adv));

  assign fp  = FP_W'(cfg.font_px) << POS_FRAC_BITS;
  assign fp3 = {2'b00, fp} + {1'b0, fp, 1'b0};

  assign cap_go    = cfg.capture_on && ((item.op == OP_END) || glyph_ok);
  assign cur_hit   = item.index == cfg.cursor_index;
  assign sel_ok    = cfg.select_begin < cfg.select_end;
  assign sel_begin = sel_ok && (item.index == cfg.select_begin);
  assign sel_end   = sel_ok && !sel_begin && (item.index == cfg.select_end);

  assign g   = glyph_ok;
  assign c   = cap_go && cur_hit;
  assign s   = cap_go && sel_end;
  assign cnt = {1'b0, g} + {1'b0, c} + {1'b0, s};

  assign s1_take = s1_valid && out_free;

  always_comb begin
    rg      = '0;
    rg.kind = KIND_GLYPH;
    rg.x    = sat_s20(32'(pen_eff) + 32'(sc_bx));
    rg.y    = sat_s20(32'(cfg.origin_y) + 32'(sc_by));
    rg.w    = sat_s20(signed'(32'(p_w >> SCALE_SHIFT)));
    rg.h    = sat_u19(signed'(32'(p_h >> SCALE_SHIFT)));
    rg.sx   = geo.x;
    rg.sy   = geo.y;
    rg.sw   = geo.w;
    rg.sh   = geo.h;

    rc      = '0;
    rc.kind = KIND_CURSOR;
    rc.x    = pen_eff;
    rc.y    = sat_s20(32'(cfg.origin_y) + signed'(32'(fp >> 3)));
    rc.w    = CURSOR_W;
    rc.h    = sat_u19(signed'(32'(fp3 >> 2)));

    rs      = '0;
    rs.kind = KIND_SELECT;
    rs.x    = sel_left;
    rs.y    = cfg.origin_y;
    rs.w    = sat_s20(32'(pen_eff) - 32'(sel_left));
    rs.h    = sat_u19(signed'(32'(fp)));

    // pack in order glyph, cursor, selection
    bundle      = '0;
    bundle.push = s1_take && (cnt != 2'd0);
    bundle.cnt  = cnt;
    bundle.r0   = g ? rg : (c ? rc : rs);
    bundle.r1   = (g && c) ? rc : rs;
    bundle.r2   = rs;
    bundle.r0.last = cnt == 2'd1;
    bundle.r1.last = cnt == 2'd2;
    bundle.r2.last = cnt == 2'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x     <= '0;
      sel_left  <= '0;
      line_open <= 1'b0;
    end else if (s1_take) begin
      if (item.op == OP_END) begin
        pen_x     <= cfg.origin_x;
        sel_left  <= '0;
        line_open <= 1'b0;
      end else begin
        line_open <= 1'b1;
        pen_x     <= glyph_ok ? pen_adv : pen_eff;
        if (cap_go && sel_begin) begin
          sel_left <= pen_eff;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/glk_outq.sv
// Result buffer: holds the up to three results of one line request and
// hands them out one per output transfer. Uses glk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module glk_outq import glk_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire bundle_t bundle,
  input  wire logic    out_ready,
  output      logic    out_valid,
  output      result_t result,
  output      logic    out_free
);

  result_t    slot [3];
  logic [1:0] cnt;
  logic [1:0] ptr;
  logic       at_end;

  assign out_valid = cnt != 2'd0;
  assign at_end    = ptr == (cnt - 2'd1);
  assign out_free  = !out_valid || (out_ready && at_end);

  always_comb begin
    case (ptr)
      2'd0:    result = slot[0];
      2'd1:    result = slot[1];
      default: result = slot[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ptr <= '0;
    end else if (bundle.push) begin
      cnt <= bundle.cnt;
      ptr <= '0;
    end else if (out_valid && out_ready) begin
      if (at_end) begin
        cnt <= '0;
        ptr <= '0;
      end else begin
        ptr <= ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bundle.push) begin
      slot[0] <= bundle.r0;
      slot[1] <= bundle.r1;
      slot[2] <= bundle.r2;
    end
  end

endmodule

`default_nettype wire

FILE: design/glyph_layout_kerning.sv
// Top level of the glyph layout block: config registers, intake, tables,
// placement and result buffer. Uses glk_pkg, assert_macros.svh, all glk_*.
//
// glyph_layout_kerning places the glyphs of a text line. Load requests
// (opcode 0 glyph, 1 kerning pair) fill a 256-entry glyph table and a
// 65536-entry kerning table. Text requests (opcode 2) look up the glyph and
// the kerning of the previous byte and this byte, give one glyph rectangle
// scaled by scale_q8 (Q8.8) in Q.4 pixels, and advance the pen. With
// capture_on set, cursor and selection rectangles follow the glyph at a
// matching character index; an end request (opcode 3) gives the captures
// for the index past the text and closes the line. Positions round toward
// minus infinity and saturate. Throughput: one request per clock as long
// as out_ready stays high and each request gives at most one result; a
// request with more results holds the result buffer until its last one is
// taken. A request passes the registered table read, then placement into
// the result buffer, before its first result. The pen update (kerning add,
// scale multiply, saturating add) is combinational within placement. After
// reset a sweep clears the kerning table, during which in_ready stays low;
// config writes are taken at any time. The user must write config only
// while no request is in flight; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module glyph_layout_kerning import glk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // request channel
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [1:0]        opcode,
  input  wire logic [7:0]        code,
  input  wire logic [7:0]        first_code,
  input  wire logic [11:0]       atlas_x,
  input  wire logic [11:0]       atlas_y,
  input  wire logic [7:0]        glyph_w,
  input  wire logic [7:0]        glyph_h,
  input  wire logic signed [7:0] bearing_x,
  input  wire logic signed [7:0] bearing_y,
  input  wire logic signed [8:0] amount,
  // result channel
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [1:0]        kind,
  output      logic signed [19:0] screen_x,
  output      logic signed [19:0] screen_y,
  output      logic signed [19:0] screen_w,
  output      logic [18:0]       screen_h,
  output      logic [11:0]       src_x,
  output      logic [11:0]       src_y,
  output      logic [7:0]        src_w,
  output      logic [7:0]        src_h,
  output      logic              last,
  // config write port
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [19:0]       cfg_data
);

`include "assert_macros.svh"

  cfg_t              cfg;
  tbl_wr_t           wr;
  tbl_rd_t           rd;
  geo_t              geo_q;
  met_t              met_q;
  logic              valid_q;
  logic signed [7:0] kern_q;
  logic              clearing;
  logic              s1_valid;
  logic              s1_take;
  item_t             item;
  bundle_t           bundle;
  logic              out_free;
  result_t           result;

  // config registers, fields truncated to their widths
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_q8     <= 16'd256;
      cfg.font_px      <= 12'd16;
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.capture_on   <= 1'b0;
      cfg.cursor_index <= '0;
      cfg.select_begin <= '0;
      cfg.select_end   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE:     cfg.scale_q8     <= cfg_data[15:0];
        REG_FONT_PX:   cfg.font_px      <= cfg_data[11:0];
        REG_ORIGIN_X:  cfg.origin_x     <= cfg_data;
        REG_ORIGIN_Y:  cfg.origin_y     <= cfg_data;
        REG_CAPTURE:   cfg.capture_on   <= cfg_data[0];
        REG_CURSOR:    cfg.cursor_index <= cfg_data[15:0];
        REG_SEL_BEGIN: cfg.select_begin <= cfg_data[15:0];
        REG_SEL_END:   cfg.select_end   <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  // intake: load requests write the tables, line requests read them
  glk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .code       (code),
    .first_code (first_code),
    .atlas_x    (atlas_x),
    .atlas_y    (atlas_y),
    .glyph_w    (glyph_w),
    .glyph_h    (glyph_h),
    .bearing_x  (bearing_x),
    .bearing_y  (bearing_y),
    .amount     (amount),
    .clearing   (clearing),
    .s1_take    (s1_take),
    .wr         (wr),
    .rd         (rd),
    .s1_valid   (s1_valid),
    .item       (item)
  );

  // read data holds while the item register is stalled
  glk_tables u_tables (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd       (rd),
    .geo_q    (geo_q),
    .met_q    (met_q),
    .valid_q  (valid_q),
    .kern_q   (kern_q),
    .clearing (clearing)
  );

  // one line request per clock moves into the buffer while out_free is set
  glk_place u_place (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .item     (item),
    .geo      (geo_q),
    .met      (met_q),
    .valid_q  (valid_q),
    .kern_q   (kern_q),
    .out_free (out_free),
    .s1_take  (s1_take),
    .bundle   (bundle)
  );

  glk_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .bundle    (bundle),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .result    (result),
    .out_free  (out_free)
  );

  assign kind     = result.kind;
  assign screen_x = result.x;
  assign screen_y = result.y;
  assign screen_w = result.w;
  assign screen_h = result.h;
  assign src_x    = result.sx;
  assign src_y    = result.sy;
  assign src_w    = result.sw;
  assign src_h    = result.sh;
  assign last     = result.last;

  // no request may enter while the kerning sweep owns the table
  `ASSERT_NEVER(a_no_req_clearing, clearing && in_ready, "request taken during clear sweep")

  // the sweep starts right out of reset
  `ASSERT_CLK(a_clear_after_rst, $past(rst) |-> clearing, "clear sweep not running after reset")

  // a new bundle only lands when the buffer is empty or drains its last result
  `ASSERT_NEVER(a_no_overwrite, bundle.push && out_valid && !(out_ready && last),
                "result bundle overwrites pending results")

  // placement advances only when the item register holds a line request
  `ASSERT_NEVER(a_take_valid, s1_take && !s1_valid, "placement without a pending item")

endmodule

`default_nettype wire
